### hdl/lmsc_pkg.sv
package lmsc_pkg;

  localparam int unsigned LlrW   = 8;
  localparam int unsigned MagW   = 7;
  localparam int unsigned VarW   = 7;
  localparam int unsigned ScaleW = 8;
  localparam int unsigned ProdW  = MagW + ScaleW;
  localparam int unsigned FracW  = 7;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [MagW-1:0] MagArm = 7'd127;

  localparam logic [1:0] RegLlrMax = 2'd0;
  localparam logic [1:0] RegLlrInf = 2'd1;
  localparam logic [1:0] RegScale  = 2'd2;

  typedef struct packed {
    logic accept;
    logic scale;
    logic emit;
    logic rearm;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } sts_t;

  function automatic logic signed [LlrW-1:0] make_v2c(
    input logic signed [LlrW-1:0] llr,
    input logic signed [LlrW-1:0] c2v,
    input logic [MagW-1:0]        mx,
    input logic [MagW-1:0]        inf
  );
    logic signed [9:0] d;
    logic signed [9:0] ssoft;
    logic signed [9:0] smx;
    logic signed [9:0] sinf;
    ssoft = {{2{llr[LlrW-1]}}, llr};
    smx   = {3'b000, mx};
    sinf  = {3'b000, inf};
    d     = ssoft - {{2{c2v[LlrW-1]}}, c2v};
    if (d > smx) d = smx;
    if (d < -smx) d = -smx;
    if (ssoft >= sinf) d = sinf;
    if (ssoft <= -sinf) d = -sinf;
    return d[LlrW-1:0];
  endfunction

  function automatic logic signed [LlrW-1:0] make_soft(
    input logic signed [LlrW-1:0] c2v,
    input logic signed [LlrW-1:0] v2c,
    input logic [MagW-1:0]        mx,
    input logic [MagW-1:0]        inf
  );
    logic signed [9:0] sc;
    logic signed [9:0] sv;
    logic signed [9:0] smx;
    logic signed [9:0] sinf;
    logic signed [9:0] s;
    logic cp;
    logic cm;
    logic vp;
    logic vm;
    sc   = {{2{c2v[LlrW-1]}}, c2v};
    sv   = {{2{v2c[LlrW-1]}}, v2c};
    smx  = {3'b000, mx};
    sinf = {3'b000, inf};
    cp   = sc > smx;
    cm   = sc < -smx;
    vp   = sv > smx;
    vm   = sv < -smx;
    s    = sc + sv;
    if (s > 10'sd127) s = 10'sd127;
    if (s < -10'sd128) s = -10'sd128;
    if (s > smx || (cp && !vm) || (vp && !cm)) s = sinf;
    if (s < -smx || (cm && !vp) || (vm && !cp)) s = -sinf;
    return s[LlrW-1:0];
  endfunction

endpackage

### hdl/lmsc_ctrl.sv
module lmsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  lmsc_pkg::sts_t      sts_i,
  output lmsc_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StScale = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StLoad: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) state_d = StScale;
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.rearm = 1'b1;
            state_d     = StLoad;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/lmsc_dp.sv
module lmsc_dp #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lmsc_pkg::cmd_t                        cmd_i,
  output lmsc_pkg::sts_t                        sts_o,
  input  logic signed [lmsc_pkg::LlrW-1:0]      soft_llr_i,
  input  logic signed [lmsc_pkg::LlrW-1:0]      old_c2v_i,
  input  logic [lmsc_pkg::VarW-1:0]             var_index_i,
  input  logic [lmsc_pkg::MagW-1:0]             llr_max_i,
  input  logic [lmsc_pkg::MagW-1:0]             llr_inf_i,
  input  logic [lmsc_pkg::ScaleW-1:0]           scale_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [lmsc_pkg::LlrW-1:0]      new_soft_o,
  output logic signed [lmsc_pkg::LlrW-1:0]      new_c2v_o,
  output logic [lmsc_pkg::VarW-1:0]             out_var_index_o,
  output logic                                  last_result_o
);

  localparam int unsigned AW = $clog2(MAX_DEGREE);
  localparam int unsigned CW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned EW = lmsc_pkg::LlrW + lmsc_pkg::VarW;

  logic [EW-1:0] mem [MAX_DEGREE];
  logic [EW-1:0] rd_q;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [lmsc_pkg::MagW-1:0] min_q, min_d, sec_q, sec_d;
  logic [lmsc_pkg::VarW-1:0] min_var_q, min_var_d;
  logic sign_q, sign_d;
  logic [lmsc_pkg::MagW-1:0] sc_min_q, sc_sec_q;
  logic out_vld_q;

  logic                              store;
  logic signed [lmsc_pkg::LlrW-1:0]  v2c;
  logic [lmsc_pkg::LlrW-1:0]         v2c_abs;
  logic [lmsc_pkg::MagW-1:0]         mag;
  logic [lmsc_pkg::ProdW-1:0]        prod_min, prod_sec;
  logic [lmsc_pkg::LlrW-1:0]         tr_min, tr_sec;
  logic [lmsc_pkg::MagW-1:0]         cap_min, cap_sec;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic signed [lmsc_pkg::LlrW-1:0]  rd_v2c;
  logic [lmsc_pkg::VarW-1:0]         rd_var;
  logic [lmsc_pkg::MagW-1:0]         sel_mag;
  logic signed [lmsc_pkg::LlrW-1:0]  nc;

  // edge tracking
  assign store   = cmd_i.accept && (count_q < CW'(MAX_DEGREE));
  assign v2c     = lmsc_pkg::make_v2c(soft_llr_i, old_c2v_i, llr_max_i, llr_inf_i);
  assign v2c_abs = v2c[lmsc_pkg::LlrW-1] ? -v2c : v2c;
  assign mag     = v2c_abs[lmsc_pkg::MagW-1:0];

  always_comb begin
    count_d   = count_q;
    min_d     = min_q;
    sec_d     = sec_q;
    min_var_d = min_var_q;
    sign_d    = sign_q;
    if (cmd_i.rearm) begin
      count_d   = '0;
      min_d     = lmsc_pkg::MagArm;
      sec_d     = lmsc_pkg::MagArm;
      min_var_d = '0;
      sign_d    = 1'b0;
    end else if (store) begin
      count_d = count_q + CW'(1);
      sign_d  = sign_q ^ v2c[lmsc_pkg::LlrW-1];
      if (min_q > mag) begin
        sec_d     = min_q;
        min_d     = mag;
        min_var_d = var_index_i;
      end else if (sec_q > mag) begin
        sec_d = mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      min_q     <= lmsc_pkg::MagArm;
      sec_q     <= lmsc_pkg::MagArm;
      min_var_q <= '0;
      sign_q    <= 1'b0;
      idx_q     <= '0;
    end else begin
      count_q   <= count_d;
      min_q     <= min_d;
      sec_q     <= sec_d;
      min_var_q <= min_var_d;
      sign_q    <= sign_d;
      idx_q     <= idx_d;
    end
  end

  // edge store
  always_ff @(posedge clk_i) begin
    if (store) mem[count_q[AW-1:0]] <= {var_index_i, v2c};
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign rd_en   = cmd_i.scale || cmd_i.emit;
  assign rd_addr = cmd_i.scale ? '0 : idx_q + AW'(1);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.scale) idx_d = '0;
    else if (cmd_i.emit) idx_d = idx_q + AW'(1);
  end

  // scaled magnitudes, one per check
  assign prod_min = lmsc_pkg::ProdW'(min_q) * lmsc_pkg::ProdW'(scale_i);
  assign prod_sec = lmsc_pkg::ProdW'(sec_q) * lmsc_pkg::ProdW'(scale_i);
  assign tr_min   = prod_min[lmsc_pkg::ProdW-1:lmsc_pkg::FracW];
  assign tr_sec   = prod_sec[lmsc_pkg::ProdW-1:lmsc_pkg::FracW];
  assign cap_min  = (tr_min > {1'b0, llr_max_i}) ? llr_max_i : tr_min[lmsc_pkg::MagW-1:0];
  assign cap_sec  = (tr_sec > {1'b0, llr_max_i}) ? llr_max_i : tr_sec[lmsc_pkg::MagW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      sc_min_q <= cap_min;
      sc_sec_q <= cap_sec;
    end
  end

  // result
  assign rd_v2c  = rd_q[lmsc_pkg::LlrW-1:0];
  assign rd_var  = rd_q[EW-1:lmsc_pkg::LlrW];
  assign sel_mag = (rd_var == min_var_q) ? sc_sec_q : sc_min_q;
  assign nc      = (rd_v2c[lmsc_pkg::LlrW-1] ^ sign_q) ? -{1'b0, sel_mag} : {1'b0, sel_mag};

  assign sts_o.idx_last = (CW'(idx_q) + CW'(1)) == count_q;
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      new_soft_o      <= lmsc_pkg::make_soft(nc, rd_v2c, llr_max_i, llr_inf_i);
      new_c2v_o       <= nc;
      out_var_index_o <= rd_var;
      last_result_o   <= sts_o.idx_last;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

### hdl/ldpc_min_sum_check_node_core.sv
// Load: one edge beat per cycle, s_axis_tready high until the tlast beat is taken.
// Emit: scale min and second min in StScale, then one result per cycle from the
//   edge store (registered read), held back only by m_axis_tready.
// Reset (rst_ni low, async): llr_max 120, llr_inf 127, scale_q 102,
//   tracker re-armed, output empty. Edge store contents are not cleared.
module ldpc_min_sum_check_node_core #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,  // soft_llr, old_c2v, var_index, pad
  input  logic                         s_axis_tlast,  // last_edge
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // new_soft, new_c2v, out_var_index, pad
  output logic                         m_axis_tlast,  // last_result
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lmsc_pkg::AddrW-1:0]   paddr,
  input  logic [lmsc_pkg::DataW-1:0]   pwdata,
  output logic [lmsc_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  logic [lmsc_pkg::MagW-1:0]   llr_max_q;
  logic [lmsc_pkg::MagW-1:0]   llr_inf_q;
  logic [lmsc_pkg::ScaleW-1:0] scale_q_q;
  logic                        wr_en;
  logic [1:0]                  reg_sel;

  lmsc_pkg::cmd_t cmd;
  lmsc_pkg::sts_t sts;

  logic signed [lmsc_pkg::LlrW-1:0] new_soft;
  logic signed [lmsc_pkg::LlrW-1:0] new_c2v;
  logic [lmsc_pkg::VarW-1:0]        out_var_index;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      llr_max_q <= 7'd120;
      llr_inf_q <= 7'd127;
      scale_q_q <= 8'd102;
    end else if (wr_en) begin
      case (reg_sel)
        lmsc_pkg::RegLlrMax: llr_max_q <= pwdata[lmsc_pkg::MagW-1:0];
        lmsc_pkg::RegLlrInf: llr_inf_q <= pwdata[lmsc_pkg::MagW-1:0];
        lmsc_pkg::RegScale:  scale_q_q <= pwdata[lmsc_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lmsc_pkg::RegLlrMax: prdata = lmsc_pkg::DataW'(llr_max_q);
      lmsc_pkg::RegLlrInf: prdata = lmsc_pkg::DataW'(llr_inf_q);
      lmsc_pkg::RegScale:  prdata = lmsc_pkg::DataW'(scale_q_q);
      default:             prdata = '0;
    endcase
  end

  lmsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lmsc_dp #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .soft_llr_i      (s_axis_tdata[7:0]),
    .old_c2v_i       (s_axis_tdata[15:8]),
    .var_index_i     (s_axis_tdata[22:16]),
    .llr_max_i       (llr_max_q),
    .llr_inf_i       (llr_inf_q),
    .scale_i         (scale_q_q),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .new_soft_o      (new_soft),
    .new_c2v_o       (new_c2v),
    .out_var_index_o (out_var_index),
    .last_result_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_var_index, new_c2v, new_soft};

endmodule

### hdl/lmsc_checker.sv
module lmsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic in_last_beat;

  assign in_last_beat = s_axis_tvalid && s_axis_tready && s_axis_tlast;

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result beat changed");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_beat |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken during scale or first emit cycle");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_beat |=> !$rose(m_axis_tvalid) ##1 !$rose(m_axis_tvalid))
    else $error("result appeared before scaling finished");

endmodule

bind ldpc_min_sum_check_node_core lmsc_checker u_lmsc_checker (.*);
